FILE: src/masked_box_downsample_2x2_unit_macros.svh
// Assertion macros for the masked 2x2 box downsampler.
`ifndef MASKED_BOX_DOWNSAMPLE_2X2_UNIT_MACROS_SVH
`define MASKED_BOX_DOWNSAMPLE_2X2_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MBD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MBD_ASSERT_IMPL(lbl, ante, cons)
`define MBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/mbd_pkg.sv
// Shared types and constants of the masked 2x2 box downsampler.
`default_nettype none
package mbd_pkg;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int ROW_W        = 12;
	localparam int MAX_HEIGHT   = 4096;
	localparam int SUM_W        = 10;
	localparam int CNT_W        = 3;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_MODE     = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       opaque;
	} px_t;

	typedef struct packed {
		px_t        top_left;
		px_t        top_right;
		px_t        bot_left;
		px_t        bot_right;
		logic [1:0] dither;
		logic       row_end;
		logic       image_end;
	} blk_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		CLS_DROP,
		CLS_STORE,
		CLS_LEFT,
		CLS_FULL
	} cls_t;

endpackage
`default_nettype wire

FILE: src/mbd_queue.sv
// Short block queue between the front and the back of the downsampler.
`default_nettype none
module mbd_queue
	import mbd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire blk_t    push_data,
	input  wire logic    pop,
	output      blk_t    head,
	output      q_stat_t stat
);

	blk_t               entry_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_AW:0]      count_q;

	assign stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/mbd_front.sv
// Front end: accepts pixels, tracks position, keeps the even-row line store, builds blocks.
`default_nettype none
`include "masked_box_downsample_2x2_unit_macros.svh"
module mbd_front
	import mbd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [WIDTH_REG_W-1:0]  source_width,
	input  wire logic [HEIGHT_REG_W-1:0] source_height,
	input  wire logic                    in_valid,
	output      logic                    in_ready,
	input  wire px_t                     in_px,
	input  wire logic [1:0]              in_dither,
	output      logic                    q_push,
	output      blk_t                    q_data,
	input  wire q_stat_t                 q_stat
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;

	px_t                    store_mem [MAX_WIDTH];
	px_t                    rd_s1;
	logic [XW-1:0]          x_q;
	logic [ROW_W-1:0]       y_q;

	logic                   valid_s1;
	cls_t                   cls_s1;
	px_t                    px_s1;
	logic [1:0]             dither_s1;
	logic                   row_end_s1;
	logic                   image_end_s1;
	px_t                    top_left_q;
	px_t                    bot_left_q;

	logic [WW-1:0]          w_eff;
	logic [WW-1:0]          ow2;
	logic [WW-1:0]          x_ext;
	logic [WW-1:0]          x_inc;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [HEIGHT_REG_W-1:0] oh2;
	logic [HEIGHT_REG_W-1:0] y_ext;
	logic [HEIGHT_REG_W-1:0] y_inc;
	logic [XW-1:0]          x_next;
	logic [ROW_W-1:0]       y_next;
	logic                   in_range;
	logic                   x_last;
	logic                   y_last;
	cls_t                   cls_d;
	logic                   s_acc;
	logic                   s1_go;

	always_comb begin
		w_eff = WW'(source_width);
		if (w_eff < WW'(2)) begin
			w_eff = WW'(2);
		end else if (w_eff > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end
		h_eff = source_height;
		if (h_eff < HEIGHT_REG_W'(2)) begin
			h_eff = HEIGHT_REG_W'(2);
		end else if (h_eff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		end
	end

	assign ow2      = {w_eff[WW-1:1], 1'b0};
	assign oh2      = {h_eff[HEIGHT_REG_W-1:1], 1'b0};
	assign x_ext    = WW'(x_q);
	assign y_ext    = HEIGHT_REG_W'(y_q);
	assign x_inc    = x_ext + 1'b1;
	assign y_inc    = y_ext + 1'b1;
	assign in_range = (x_ext < ow2) && (y_ext < oh2);
	assign x_last   = (x_ext == ow2 - 1'b1);
	assign y_last   = (y_ext == oh2 - 1'b1);

	always_comb begin
		x_next = x_q;
		y_next = y_q;
		if (x_inc >= w_eff) begin
			x_next = '0;
			if (y_inc >= h_eff) begin
				y_next = '0;
			end else begin
				y_next = y_inc[ROW_W-1:0];
			end
		end else begin
			x_next = x_inc[XW-1:0];
		end
	end

	always_comb begin
		priority if (!in_range) begin
			cls_d = CLS_DROP;
		end else if (!y_q[0]) begin
			cls_d = CLS_STORE;
		end else if (!x_q[0]) begin
			cls_d = CLS_LEFT;
		end else begin
			cls_d = CLS_FULL;
		end
	end

	assign s1_go    = (cls_s1 != CLS_FULL) || !q_stat.full;
	assign in_ready = !valid_s1 || s1_go;
	assign s_acc    = in_valid && in_ready;
	assign q_push   = valid_s1 && (cls_s1 == CLS_FULL) && !q_stat.full;

	assign q_data.top_left  = top_left_q;
	assign q_data.top_right = rd_s1;
	assign q_data.bot_left  = bot_left_q;
	assign q_data.bot_right = px_s1;
	assign q_data.dither    = dither_s1;
	assign q_data.row_end   = row_end_s1;
	assign q_data.image_end = image_end_s1;

	// line store: even rows write, odd rows read one column per request
	always_ff @(posedge clk) begin
		if (s_acc && cls_d == CLS_STORE) begin
			store_mem[x_q] <= in_px;
		end
		if (s_acc && (cls_d == CLS_LEFT || cls_d == CLS_FULL)) begin
			rd_s1 <= store_mem[x_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			px_s1        <= in_px;
			dither_s1    <= in_dither;
			row_end_s1   <= x_last;
			image_end_s1 <= x_last && y_last;
		end
		if (valid_s1 && cls_s1 == CLS_LEFT) begin
			top_left_q <= rd_s1;
			bot_left_q <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			valid_s1 <= 1'b0;
			cls_s1   <= CLS_DROP;
		end else begin
			if (s_acc) begin
				x_q      <= x_next;
				y_q      <= y_next;
				valid_s1 <= 1'b1;
				cls_s1   <= cls_d;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	`MBD_ASSERT_NEXT(a_stall_hold, valid_s1 && !s1_go, valid_s1 && $stable(cls_s1) && $stable(rd_s1))
	`MBD_ASSERT_IMPL(a_full_blocks, valid_s1 && cls_s1 == CLS_FULL && q_stat.full, !in_ready)
	`MBD_ASSERT_NEXT(a_col_moves, s_acc, x_q != $past(x_q))

endmodule
`default_nettype wire

FILE: src/mbd_back.sv
// Back end: averages a queued 2x2 block and holds the result for the output stream.
`default_nettype none
module mbd_back
	import mbd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    hole_mode,
	input  wire blk_t    head,
	input  wire q_stat_t q_stat,
	output      logic    q_pop,
	output      logic    out_valid,
	input  wire logic    out_ready,
	output      px_t     out_px,
	output      logic    out_row_end,
	output      logic    out_image_end
);

	function automatic logic [7:0] div_cnt(input logic [SUM_W-1:0] sum,
	                                       input logic [CNT_W-1:0] cnt);
		logic [SUM_W+10:0] prod;
		logic [7:0]        res;
		prod = (SUM_W+11)'(sum) * (SUM_W+11)'(683);
		unique case (cnt)
			3'd1:    res = sum[7:0];
			3'd2:    res = sum[8:1];
			3'd3:    res = prod[18:11];
			default: res = sum[9:2];
		endcase
		return res;
	endfunction

	logic                   sum_valid_s1;
	logic [SUM_W-1:0]       sr_s1;
	logic [SUM_W-1:0]       sg_s1;
	logic [SUM_W-1:0]       sb_s1;
	logic [CNT_W-1:0]       cnt_s1;
	logic                   opq_s1;
	logic                   row_end_s1;
	logic                   image_end_s1;
	logic                   out_valid_q;
	px_t                    out_px_q;
	logic                   row_end_q;
	logic                   image_end_q;

	px_t                    quad [4];
	logic [SUM_W-1:0]       sr_d;
	logic [SUM_W-1:0]       sg_d;
	logic [SUM_W-1:0]       sb_d;
	logic [CNT_W-1:0]       cnt_d;
	logic                   opq_d;
	logic                   adv_out;

	assign adv_out = !out_valid_q || out_ready;
	assign q_pop   = !q_stat.empty && (!sum_valid_s1 || adv_out);

	assign quad[0] = head.top_left;
	assign quad[1] = head.top_right;
	assign quad[2] = head.bot_left;
	assign quad[3] = head.bot_right;

	always_comb begin
		sr_d  = '0;
		sg_d  = '0;
		sb_d  = '0;
		cnt_d = '0;
		for (int i = 0; i < 4; i++) begin
			if (!hole_mode || quad[i].opaque) begin
				sr_d  = sr_d + SUM_W'(quad[i].red);
				sg_d  = sg_d + SUM_W'(quad[i].green);
				sb_d  = sb_d + SUM_W'(quad[i].blue);
				cnt_d = cnt_d + 1'b1;
			end
		end
		opq_d = !hole_mode || (cnt_d > CNT_W'(head.dither));
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sr_s1        <= sr_d;
			sg_s1        <= sg_d;
			sb_s1        <= sb_d;
			cnt_s1       <= cnt_d;
			opq_s1       <= opq_d;
			row_end_s1   <= head.row_end;
			image_end_s1 <= head.image_end;
		end
		if (sum_valid_s1 && adv_out) begin
			if (opq_s1) begin
				out_px_q.red    <= div_cnt(sr_s1, cnt_s1);
				out_px_q.green  <= div_cnt(sg_s1, cnt_s1);
				out_px_q.blue   <= div_cnt(sb_s1, cnt_s1);
				out_px_q.opaque <= 1'b1;
			end else begin
				out_px_q <= '0;
			end
			row_end_q   <= row_end_s1;
			image_end_q <= image_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				sum_valid_s1 <= 1'b1;
			end else if (adv_out) begin
				sum_valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= sum_valid_s1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_px        = out_px_q;
	assign out_row_end   = row_end_q;
	assign out_image_end = image_end_q;

endmodule
`default_nettype wire

FILE: src/masked_box_downsample_2x2_unit.sv
// Top level of the masked 2x2 box downsampler.
// Takes source pixels in raster order, one per cycle at full rate while the block
// queue has room, and emits one half-size pixel for each 2x2 block when the second
// pixel of the block's lower pair arrives; odd trailing columns and rows produce
// nothing. Sustained rate is one source pixel per cycle, set by the single-port line
// store that even rows write and odd rows read once per pixel. A result passes through
// the line store read at acceptance, then the block queue, sum stage and output
// register. A four-entry block queue lets the output stall without stopping input
// until it fills. Geometry and mode are to be written only while the block is idle;
// the block itself does not enforce this. The line store needs no clearing after reset.
`default_nettype none
module masked_box_downsample_2x2_unit
	import mbd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output      logic                  s_tready,
	input  wire logic [31:0]           s_tdata,  // red_in, green_in, blue_in, opaque_in, dither
	output      logic                  m_tvalid,
	input  wire logic                  m_tready,
	output      logic [31:0]           m_tdata,  // red_out, green_out, blue_out, opaque_out
	output      logic                  m_tlast,
	output      logic                  m_tuser   // image_end
);

	logic [WIDTH_REG_W-1:0]  source_width_q;
	logic [HEIGHT_REG_W-1:0] source_height_q;
	logic                    hole_mode_q;

	px_t        in_px;
	px_t        out_px;
	logic       q_push;
	logic       q_pop;
	blk_t       q_data;
	blk_t       q_head;
	q_stat_t    q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= WIDTH_REG_W'(1024);
			source_height_q <= HEIGHT_REG_W'(1024);
			hole_mode_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				REG_HOLE_MODE:     hole_mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_px.red    = s_tdata[7:0];
	assign in_px.green  = s_tdata[15:8];
	assign in_px.blue   = s_tdata[23:16];
	assign in_px.opaque = s_tdata[24];

	mbd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_width (source_width_q),
		.source_height(source_height_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_px        (in_px),
		.in_dither    (s_tdata[26:25]),
		.q_push       (q_push),
		.q_data       (q_data),
		.q_stat       (q_stat)
	);

	mbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_data),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	mbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.hole_mode    (hole_mode_q),
		.head         (q_head),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_px       (out_px),
		.out_row_end  (m_tlast),
		.out_image_end(m_tuser)
	);

	assign m_tdata = {7'd0, out_px.opaque, out_px.blue, out_px.green, out_px.red};

endmodule
`default_nettype wire
